FILE: sv/ssfd_pkg.sv
// shared types, constants and glyph tables for the seven segment frame driver
package ssfd_pkg;

  localparam int DIGIT_COUNT_DEF = 8;
  localparam int CLEAR_BYTES_DEF = 32;

  localparam int MAX_DIGITS = 8;
  localparam int GI_W       = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W     = 6;
  localparam int Q_DEPTH    = 2;

  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 27;
  localparam int TEXT_W     = 64;
  localparam int POS_W      = 4;

  localparam logic [7:0] CMD_AUTO_INC = 8'h40;
  localparam logic [7:0] CMD_FIXED    = 8'h44;
  localparam logic [7:0] ADDR_BASE    = 8'hC0;
  localparam logic [7:0] LED_BASE     = 8'hC1;
  localparam logic [7:0] BLANK        = 8'h00;

  // reciprocal of ten, exact for any 32 bit dividend after the shift
  localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_TEXT   = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_LED    = 3'd4,
    MODE_RAW    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_LIST,
    JOB_FIXED,
    JOB_RAW
  } job_kind_t;

  typedef enum logic {
    F_IDLE,
    F_CONV
  } front_state_t;

  typedef struct packed {
    job_kind_t                       kind;
    logic [CNT_W-1:0]                cnt;
    logic [MAX_DIGITS-1:0][7:0]      glyph;
    logic [7:0]                      addr;
    logic [7:0]                      data;
  } job_t;

  localparam logic [7:0] HEX_GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  // glyphs for printable codes 32..126
  localparam logic [7:0] ASCII_GLYPH [95] = '{
    8'h00, 8'hC6, 8'h22, 8'h7E, 8'h6D, 8'h00, 8'h00, 8'h02,
    8'h30, 8'h06, 8'h63, 8'h00, 8'h04, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h6B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
    8'h5F, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h1F, 8'h69, 8'h38, 8'h55, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h2A, 8'h3D,
    8'h76, 8'h6E, 8'h6B, 8'h39, 8'h64, 8'h0F, 8'h00, 8'h08,
    8'h20, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h31, 8'h6F,
    8'h74, 8'h04, 8'h0E, 8'h75, 8'h30, 8'h55, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h2A, 8'h1D,
    8'h76, 8'h6E, 8'h47, 8'h46, 8'h06, 8'h70, 8'h01
  };

  function automatic logic [7:0] char_glyph(input logic [7:0] c);
    logic [6:0] idx;
    logic [7:0] g;
    idx = 7'(c - 8'd32);
    if (c < 8'd32 || c > 8'd126) begin
      g = BLANK;
    end else begin
      g = ASCII_GLYPH[idx];
    end
    return g;
  endfunction

endpackage

FILE: sv/ssfd_req_if.sv
// request channel: mode, value, text and position with valid/ready
interface ssfd_req_if;
  logic                            valid;
  logic                            ready;
  logic [ssfd_pkg::MODE_W-1:0]     mode;
  logic [ssfd_pkg::VALUE_W-1:0]    value;
  logic [ssfd_pkg::TEXT_W-1:0]     text;
  logic [ssfd_pkg::POS_W-1:0]      position;

  modport source (output valid, mode, value, text, position, input ready);
  modport sink   (input valid, mode, value, text, position, output ready);
endinterface

FILE: sv/ssfd_byte_if.sv
// byte channel: one framed byte per item with valid/ready
interface ssfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;
  logic       last;

  modport source (output valid, data_byte, frame_start, frame_end, last, input ready);
  modport sink   (input valid, data_byte, frame_start, frame_end, last, output ready);
endinterface

FILE: sv/ssfd_front.sv
// front end: accepts requests and turns them into byte jobs
module ssfd_front #(
  parameter int DIGIT_COUNT = ssfd_pkg::DIGIT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ssfd_req_if.sink       request,
  output logic           job_valid,
  input  logic           job_ready,
  output ssfd_pkg::job_t job
);

  localparam int PROD_W = ssfd_pkg::VALUE_W + 32;
  localparam int Q_W    = PROD_W - ssfd_pkg::DIV10_SHIFT;
  localparam logic [ssfd_pkg::GI_W-1:0] LAST_K = ssfd_pkg::GI_W'(DIGIT_COUNT - 1);

  ssfd_pkg::front_state_t          state, state_next;
  logic [ssfd_pkg::VALUE_W-1:0]    conv_v, conv_v_next;
  logic [ssfd_pkg::GI_W-1:0]       conv_k, conv_k_next;
  ssfd_pkg::job_t                  job_next;
  logic                            job_valid_next;

  logic [PROD_W-1:0]               prod;
  logic [Q_W-1:0]                  quot;
  logic [ssfd_pkg::VALUE_W-1:0]    quot10;
  logic [3:0]                      digit;
  logic [ssfd_pkg::CNT_W-1:0]      text_len;
  logic [ssfd_pkg::MAX_DIGITS-1:0][7:0] text_glyph;
  logic                            accept;

  // one decimal digit per cycle, least significant first
  assign prod   = PROD_W'(conv_v) * PROD_W'(ssfd_pkg::DIV10_RECIP);
  assign quot   = prod[PROD_W-1:ssfd_pkg::DIV10_SHIFT];
  assign quot10 = ssfd_pkg::VALUE_W'({quot, 3'b000}) + ssfd_pkg::VALUE_W'({quot, 1'b0});
  assign digit  = 4'(conv_v - quot10);

  // text length up to first zero byte or DIGIT_COUNT characters, glyph per character
  always_comb begin
    logic stop;
    stop     = 1'b0;
    text_len = '0;
    for (int i = 0; i < ssfd_pkg::MAX_DIGITS; i++) begin
      text_glyph[i] = ssfd_pkg::char_glyph(request.text[8*i +: 8]);
      if (i < DIGIT_COUNT && !stop && request.text[8*i +: 8] != 8'h00) begin
        text_len = text_len + 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign request.ready = (state == ssfd_pkg::F_IDLE) && (!job_valid || job_ready);
  assign accept        = request.valid && request.ready;

  always_comb begin
    state_next     = state;
    conv_v_next    = conv_v;
    conv_k_next    = conv_k;
    job_next       = job;
    job_valid_next = job_valid && !job_ready;
    case (state)
      ssfd_pkg::F_IDLE: begin
        if (accept) begin
          case (ssfd_pkg::mode_t'(request.mode))
            ssfd_pkg::MODE_CLEAR: begin
              job_next.kind  = ssfd_pkg::JOB_CLEAR;
              job_valid_next = 1'b1;
            end
            ssfd_pkg::MODE_NUMBER: begin
              job_next.kind = ssfd_pkg::JOB_LIST;
              job_next.cnt  = ssfd_pkg::CNT_W'(DIGIT_COUNT);
              conv_v_next   = request.value;
              conv_k_next   = '0;
              state_next    = ssfd_pkg::F_CONV;
            end
            ssfd_pkg::MODE_TEXT: begin
              job_next.kind  = ssfd_pkg::JOB_LIST;
              job_next.cnt   = text_len;
              job_next.glyph = text_glyph;
              job_valid_next = 1'b1;
            end
            ssfd_pkg::MODE_HEX: begin
              job_next.kind  = ssfd_pkg::JOB_FIXED;
              job_next.addr  = ssfd_pkg::ADDR_BASE | 8'(request.position);
              job_next.data  = ssfd_pkg::HEX_GLYPH[request.value[3:0]];
              job_valid_next = 1'b1;
            end
            ssfd_pkg::MODE_LED: begin
              job_next.kind  = ssfd_pkg::JOB_FIXED;
              job_next.addr  = 8'(ssfd_pkg::LED_BASE + 8'({request.position, 1'b0}));
              job_next.data  = request.value[7:0];
              job_valid_next = 1'b1;
            end
            ssfd_pkg::MODE_RAW: begin
              job_next.kind  = ssfd_pkg::JOB_RAW;
              job_next.data  = request.value[7:0];
              job_valid_next = 1'b1;
            end
            default: begin
              // unused mode codes are dropped
            end
          endcase
        end
      end
      ssfd_pkg::F_CONV: begin
        job_next.glyph[LAST_K - conv_k] = ssfd_pkg::HEX_GLYPH[digit];
        conv_v_next = ssfd_pkg::VALUE_W'(quot);
        conv_k_next = conv_k + 1'b1;
        if (conv_k == LAST_K) begin
          state_next     = ssfd_pkg::F_IDLE;
          job_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = ssfd_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssfd_pkg::F_IDLE;
      job_valid <= 1'b0;
    end else begin
      state     <= state_next;
      job_valid <= job_valid_next;
    end
    conv_v <= conv_v_next;
    conv_k <= conv_k_next;
    job    <= job_next;
  end

endmodule

FILE: sv/ssfd_queue.sv
// short job queue between front and back
module ssfd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssfd_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output ssfd_pkg::job_t out_job
);

  localparam int PW = $clog2(ssfd_pkg::Q_DEPTH);

  ssfd_pkg::job_t   slots [ssfd_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      count;
  logic             push, pop;

  assign in_ready  = count != (PW+1)'(ssfd_pkg::Q_DEPTH);
  assign out_valid = count != '0;
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) slots[wr_ptr] <= in_job;
  end

endmodule

FILE: sv/ssfd_back.sv
// back end: steps through a job and emits one framed byte per cycle while the output is not stalled
module ssfd_back #(
  parameter int CLEAR_BYTES = ssfd_pkg::CLEAR_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  ssfd_pkg::job_t job_in,
  ssfd_byte_if.source    stream
);

  localparam logic [ssfd_pkg::STEP_W-1:0] CLEAR_LAST = ssfd_pkg::STEP_W'(CLEAR_BYTES + 1);

  ssfd_pkg::job_t                 job;
  logic                           active;
  logic [ssfd_pkg::STEP_W-1:0]    step, k;
  logic [ssfd_pkg::GI_W-1:0]      gi;
  logic                           adv;
  logic [7:0]                     b;
  logic                           fs, fe, is_last;
  logic                           o_valid;
  logic [7:0]                     o_byte;
  logic                           o_fs, o_fe, o_last;

  assign k  = step - ssfd_pkg::STEP_W'(2);
  assign gi = k[ssfd_pkg::GI_W:1];

  always_comb begin
    b       = ssfd_pkg::BLANK;
    fs      = 1'b0;
    fe      = 1'b0;
    is_last = 1'b0;
    case (job.kind)
      ssfd_pkg::JOB_CLEAR, ssfd_pkg::JOB_LIST: begin
        if (step == '0) begin
          b  = ssfd_pkg::CMD_AUTO_INC;
          fs = 1'b1;
          fe = 1'b1;
        end else if (step == ssfd_pkg::STEP_W'(1)) begin
          b  = ssfd_pkg::ADDR_BASE;
          fs = 1'b1;
          // empty text closes the frame on the address byte
          if (job.kind == ssfd_pkg::JOB_LIST && job.cnt == '0) begin
            fe      = 1'b1;
            is_last = 1'b1;
          end
        end else if (job.kind == ssfd_pkg::JOB_CLEAR) begin
          fe      = step == CLEAR_LAST;
          is_last = step == CLEAR_LAST;
        end else begin
          // glyph on even steps, spacer byte on odd steps
          b       = k[0] ? ssfd_pkg::BLANK : job.glyph[gi];
          fe      = k[0] && (ssfd_pkg::CNT_W'(gi) + 1'b1 == job.cnt);
          is_last = fe;
        end
      end
      ssfd_pkg::JOB_FIXED: begin
        if (step == '0) begin
          b  = ssfd_pkg::CMD_FIXED;
          fs = 1'b1;
          fe = 1'b1;
        end else if (step == ssfd_pkg::STEP_W'(1)) begin
          b  = job.addr;
          fs = 1'b1;
        end else begin
          b       = job.data;
          fe      = 1'b1;
          is_last = 1'b1;
        end
      end
      ssfd_pkg::JOB_RAW: begin
        b       = job.data;
        fs      = 1'b1;
        fe      = 1'b1;
        is_last = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  assign adv       = active && (!o_valid || stream.ready);
  assign job_ready = !active || (adv && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        active <= 1'b1;
      end else if (adv && is_last) begin
        active <= 1'b0;
      end
      if (adv) begin
        o_valid <= 1'b1;
      end else if (stream.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (job_valid && job_ready) begin
      job  <= job_in;
      step <= '0;
    end else if (adv) begin
      step <= step + 1'b1;
    end
    if (adv) begin
      o_byte <= b;
      o_fs   <= fs;
      o_fe   <= fe;
      o_last <= is_last;
    end
  end

  assign stream.valid       = o_valid;
  assign stream.data_byte   = o_byte;
  assign stream.frame_start = o_fs;
  assign stream.frame_end   = o_fe;
  assign stream.last        = o_last;

endmodule

FILE: sv/seven_segment_frame_driver.sv
// top level: request front end, job queue and byte sequencer
// Each request becomes a run of framed bytes for a serial 7-segment/LED driver chip;
// frame_start means strobe drops before the byte, frame_end means strobe rises after
// it, last marks the final byte of the request. The byte sequencer in the back end
// emits one byte per cycle while the output is not stalled; a request makes as many bytes
// as follows: clear CLEAR_BYTES+2 (34 by default), a number 2+2*DIGIT_COUNT (18), text
// 2 to 2+2*DIGIT_COUNT, hex digit and LED 3, raw command 1; unused mode codes are taken
// and produce nothing. The front end decodes a request straight into a registered job,
// except a number, whose decimal digits come from a divide-by-ten unit at one digit per
// cycle; this overlaps with the output of earlier requests through a two-entry job
// queue. Results sit in an output register, so new requests are still taken while a
// byte waits to be read, until the job queue and the front job register are full.
module seven_segment_frame_driver #(
  parameter int DIGIT_COUNT = ssfd_pkg::DIGIT_COUNT_DEF,
  parameter int CLEAR_BYTES = ssfd_pkg::CLEAR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ssfd_req_if.sink    request,
  ssfd_byte_if.source stream
);

  // classified jobs from front to queue
  ssfd_pkg::job_t fq_job;
  logic           fq_valid, fq_ready;

  // jobs from queue to sequencer
  ssfd_pkg::job_t qb_job;
  logic           qb_valid, qb_ready;

  ssfd_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  ssfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  // sequencer owns the output register
  ssfd_back #(
    .CLEAR_BYTES (CLEAR_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_in    (qb_job),
    .stream    (stream)
  );

endmodule

FILE: test/tb.sv
// testbench for seven_segment_frame_driver: directed and random requests, byte-level check
module tb;
  import ssfd_pkg::*;

  // mode codes the block takes and drops without any output
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam logic [VALUE_W-1:0] VALUE_ONES = {VALUE_W{1'b1}};
  localparam int DRAIN_CYCLES = 60;

  // segment patterns for hex digits 0..f
  localparam logic [7:0] SEG_HEX [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  // segment patterns for printable codes, space first
  localparam logic [7:0] SEG_ASCII [95] = '{
    8'h00, 8'hC6, 8'h22, 8'h7E, 8'h6D, 8'h00, 8'h00, 8'h02,
    8'h30, 8'h06, 8'h63, 8'h00, 8'h04, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h6B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
    8'h5F, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h1F, 8'h69, 8'h38, 8'h55, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h2A, 8'h3D,
    8'h76, 8'h6E, 8'h6B, 8'h39, 8'h64, 8'h0F, 8'h00, 8'h08,
    8'h20, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h31, 8'h6F,
    8'h74, 8'h04, 8'h0E, 8'h75, 8'h30, 8'h55, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h2A, 8'h1D,
    8'h76, 8'h6E, 8'h47, 8'h46, 8'h06, 8'h70, 8'h01
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;
  } frame_byte_t;

  logic clk;
  logic rst;

  ssfd_req_if  req_ch ();
  ssfd_byte_if byte_ch ();

  seven_segment_frame_driver uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .stream  (byte_ch)
  );

  // bytes still owed by the block, oldest first
  frame_byte_t pending_bytes [$];
  int error_count = 0;

  // idling controls shared by the test tasks and the receiver
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_left      = 0;
  int stall_left     = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // the run ends here if the block hangs or loses bytes
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 30);
  endfunction

  function automatic frame_byte_t framed(logic [7:0] d, logic fs, logic fe);
    return '{d, fs, fe, 1'b0};
  endfunction

  // codes outside the printable range show nothing
  function automatic logic [7:0] segment_of_char(logic [7:0] c);
    if (c < 8'd32 || c > 8'd126) begin
      return 8'h00;
    end
    return SEG_ASCII[c - 8'd32];
  endfunction

  // expected byte run for one accepted request, appended to pending_bytes
  function automatic void predict_frame_bytes(logic [MODE_W-1:0] mode,
                                              logic [VALUE_W-1:0] value,
                                              logic [TEXT_W-1:0] text,
                                              logic [POS_W-1:0] position);
    frame_byte_t run [$];
    int unsigned num;
    int unsigned dig [DIGIT_COUNT_DEF];
    int len;
    case (mode)
      MODE_CLEAR: begin
        run.push_back(framed(CMD_AUTO_INC, 1'b1, 1'b1));
        run.push_back(framed(ADDR_BASE, 1'b1, 1'b0));
        for (int i = 0; i < CLEAR_BYTES_DEF; i++) begin
          run.push_back(framed(8'h00, 1'b0, i == CLEAR_BYTES_DEF - 1));
        end
      end
      MODE_NUMBER: begin
        // digits above the display width simply fall away
        num = value;
        for (int i = 0; i < DIGIT_COUNT_DEF; i++) begin
          dig[i] = num % 10;
          num = num / 10;
        end
        run.push_back(framed(CMD_AUTO_INC, 1'b1, 1'b1));
        run.push_back(framed(ADDR_BASE, 1'b1, 1'b0));
        for (int i = DIGIT_COUNT_DEF - 1; i >= 0; i--) begin
          run.push_back(framed(SEG_HEX[dig[i]], 1'b0, 1'b0));
          run.push_back(framed(8'h00, 1'b0, i == 0));
        end
      end
      MODE_TEXT: begin
        len = 0;
        while (len < DIGIT_COUNT_DEF && text[8*len +: 8] != 8'h00) begin
          len++;
        end
        run.push_back(framed(CMD_AUTO_INC, 1'b1, 1'b1));
        // empty text closes the frame on the address byte
        run.push_back(framed(ADDR_BASE, 1'b1, len == 0));
        for (int i = 0; i < len; i++) begin
          run.push_back(framed(segment_of_char(text[8*i +: 8]), 1'b0, 1'b0));
          run.push_back(framed(8'h00, 1'b0, i == len - 1));
        end
      end
      MODE_HEX: begin
        run.push_back(framed(CMD_FIXED, 1'b1, 1'b1));
        run.push_back(framed(ADDR_BASE | {4'h0, position}, 1'b1, 1'b0));
        run.push_back(framed(SEG_HEX[value[3:0]], 1'b0, 1'b1));
      end
      MODE_LED: begin
        // no range check on the led index
        run.push_back(framed(CMD_FIXED, 1'b1, 1'b1));
        run.push_back(framed(8'(LED_BASE + {3'b000, position, 1'b0}), 1'b1, 1'b0));
        run.push_back(framed(value[7:0], 1'b0, 1'b1));
      end
      MODE_RAW: begin
        run.push_back(framed(value[7:0], 1'b1, 1'b1));
      end
      default: begin
      end
    endcase
    if (run.size() > 0) begin
      run[run.size() - 1].last = 1'b1;
    end
    foreach (run[i]) begin
      pending_bytes.push_back(run[i]);
    end
  endfunction

  // offer one request, hold it until taken, then maybe idle a while
  task automatic send_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                              logic [TEXT_W-1:0] text, logic [POS_W-1:0] position);
    int gap;
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= mode;
    req_ch.value    <= value;
    req_ch.text     <= text;
    req_ch.position <= position;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    predict_frame_bytes(mode, value, text, position);
    gap = idle_gap(sender_idles);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // first character in the low byte
  function automatic logic [TEXT_W-1:0] pack_text(string s);
    logic [TEXT_W-1:0] t;
    t = '0;
    for (int i = 0; i < s.len() && i < 8; i++) begin
      t[8*i +: 8] = s[i];
    end
    return t;
  endfunction

  // mostly well-formed strings, the rest raw noise with junk after the end
  function automatic logic [TEXT_W-1:0] random_text();
    logic [TEXT_W-1:0] t;
    int len;
    t = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      return t;
    end
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        t[8*i +: 8] = 8'($urandom_range(1, 255));
      end else begin
        t[8*i +: 8] = 8'($urandom_range(32, 126));
      end
    end
    if (len < 8) begin
      t[8*len +: 8] = 8'h00;
    end
    return t;
  endfunction

  function automatic logic [VALUE_W-1:0] random_number();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return VALUE_W'($urandom_range(0, 99_999_999));
    end else if (r < 8) begin
      return VALUE_W'($urandom);
    end
    return VALUE_W'($urandom_range(0, 999));
  endfunction

  // one random request; returns 0 for the ignored mode codes
  task automatic send_random_request(output bit counted);
    logic [MODE_W-1:0] mode;
    logic [VALUE_W-1:0] value;
    int r;
    r = $urandom_range(0, 99);
    value = VALUE_W'($urandom);
    if (r < 8) begin
      mode = MODE_CLEAR;
    end else if (r < 28) begin
      mode = MODE_NUMBER;
      value = random_number();
    end else if (r < 53) begin
      mode = MODE_TEXT;
    end else if (r < 68) begin
      mode = MODE_HEX;
    end else if (r < 83) begin
      mode = MODE_LED;
    end else if (r < 95) begin
      mode = MODE_RAW;
    end else begin
      mode = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
    end
    counted = (mode != MODE_SPARE_A && mode != MODE_SPARE_B);
    send_request(mode, value, random_text(), POS_W'($urandom));
  endtask

  // receiver: random stalls, plus a long hold-off when a test asks for one
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        byte_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        byte_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        byte_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0 && idle_gap(receiver_idles) > 0) begin
        byte_ch.ready <= 1'b0;
        stall_left = idle_gap(1'b1);
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // every byte taken is held against the oldest expectation
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h, expected nothing", $time, byte_ch.data_byte);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("data_byte", want.data_byte, byte_ch.data_byte);
        check_field("frame_start", 8'(want.frame_start), 8'(byte_ch.frame_start));
        check_field("frame_end", 8'(want.frame_end), 8'(byte_ch.frame_end));
        check_field("last", 8'(want.last), 8'(byte_ch.last));
      end
    end
  end

  // edge cases of every mode
  task automatic test_directed_modes();
    send_request(MODE_CLEAR, '0, '0, '0);
    send_request(MODE_NUMBER, '0, '0, '0);
    send_request(MODE_NUMBER, 27'd9, '0, '0);
    send_request(MODE_NUMBER, 27'd12345678, '0, '0);
    send_request(MODE_NUMBER, 27'd99999999, '0, '0);
    // ninth digit gets dropped
    send_request(MODE_NUMBER, VALUE_ONES, '1, '1);
    // empty text
    send_request(MODE_TEXT, '0, '0, '0);
    send_request(MODE_TEXT, '0, pack_text("HELLO!09"), '0);
    // stops at the zero byte, junk behind it
    send_request(MODE_TEXT, '0, 64'hA5A5_A5A5_A500_0000 | pack_text("ab"), '0);
    // codes with no glyph mixed with both ends of the printable range
    send_request(MODE_TEXT, '0, 64'h4101_7E20_FF80_7F1F, '0);
    send_request(MODE_TEXT, VALUE_ONES, '1, '1);
    send_request(MODE_HEX, '0, '0, '0);
    send_request(MODE_HEX, VALUE_ONES, '1, 4'hF);
    send_request(MODE_HEX, 27'h5A, '0, 4'h9);
    send_request(MODE_LED, 27'hFF, '0, 4'h0);
    send_request(MODE_LED, '0, '0, 4'h7);
    // led index past the last led
    send_request(MODE_LED, 27'h7FFFF01, '0, 4'hF);
    send_request(MODE_RAW, '0, '0, '0);
    send_request(MODE_RAW, VALUE_ONES, '1, '1);
    // spare mode codes produce nothing
    send_request(MODE_SPARE_A, VALUE_ONES, '1, '1);
    send_request(MODE_SPARE_B, '0, '0, '0);
    send_request(MODE_RAW, 27'h3C, '0, '0);
  endtask

  task automatic test_random_requests(int count);
    bit counted;
    int done;
    done = 0;
    while (done < count) begin
      send_random_request(counted);
      if (counted) begin
        done++;
      end
    end
  endtask

  // receiver holds off while long requests keep coming, so the input backs up
  task automatic test_back_pressure();
    hold_left = 300;
    for (int i = 0; i < 8; i++) begin
      if (i[0]) begin
        send_request(MODE_NUMBER, random_number(), '0, '0);
      end else begin
        send_request(MODE_CLEAR, VALUE_W'($urandom), {$urandom, $urandom}, POS_W'($urandom));
      end
    end
  endtask

  // no gaps on either side
  task automatic test_streaming();
    bit counted;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (int i = 0; i < 24; i++) begin
      send_random_request(counted);
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.mode      = '0;
    req_ch.value     = '0;
    req_ch.text      = '0;
    req_ch.position  = '0;
    byte_ch.ready    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_modes();
    test_back_pressure();
    test_random_requests(190);
    test_streaming();

    // let the last bytes drain, then a short quiet period for strays
    req_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ssfd_pkg.sv
sv/ssfd_req_if.sv
sv/ssfd_byte_if.sv
sv/ssfd_front.sv
sv/ssfd_queue.sv
sv/ssfd_back.sv
sv/seven_segment_frame_driver.sv
test/tb.sv
